// ===== sv/fpbe_pkg.sv =====
`default_nettype none

package fpbe_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SizeW   = 24;

  // default width of the length fields
  localparam int unsigned LengthBitsDefault = 32;

  // outcome codes
  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusBadSig    = 2'd1;
  localparam logic [StatusW-1:0] StatusNoPicture = 2'd2;
  localparam logic [StatusW-1:0] StatusTruncated = 2'd3;

  // one result transaction
  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               out_valid;
    logic               picture_last;
    logic               done_res;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/flac_picture_block_extractor.sv =====
// Streams a file in one byte per transaction, checks the fLaC signature,
// walks the metadata block headers and emits the payload bytes of the
// first usable picture block, flagging the last one, followed by a single
// outcome (ok, bad signature, no picture, truncated). The block takes one
// byte every cycle; the byte's result lands in an output register when the
// byte is accepted, and the input stalls only while that register holds a
// result that the downstream side is stalling. Asserting end_of_file on the
// final byte reports the outcome if still open and rearms the parser for
// the next file.

`default_nettype none

module flac_picture_block_extractor #(
  parameter int unsigned LengthBits = fpbe_pkg::LengthBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [fpbe_pkg::ByteW-1:0]   data_byte_i,
  input  wire logic                         end_of_file_i,
  // result channel
  output logic                              res_valid_o,
  input  wire logic                         res_stall_i,
  output logic [fpbe_pkg::ByteW-1:0]        out_byte_o,
  output logic                              out_valid_o,
  output logic                              picture_last_o,
  output logic                              done_res_o,
  output logic [fpbe_pkg::StatusW-1:0]      status_o
);

  logic           in_accept;
  logic           res_valid;
  fpbe_pkg::res_t res;
  logic           valid_q;
  fpbe_pkg::res_t res_q;

  // input taken whenever the result register is free or draining
  assign in_stall_o = valid_q & res_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  fpbe_parser #(
    .LengthBits (LengthBits)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (in_accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .res_o         (res),
    .res_valid_o   (res_valid)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_accept) begin
      valid_q <= res_valid;
    end else if (!res_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      res_q <= res;
    end
  end

  assign res_valid_o    = valid_q;
  assign out_byte_o     = res_q.out_byte;
  assign out_valid_o    = res_q.out_valid;
  assign picture_last_o = res_q.picture_last;
  assign done_res_o     = res_q.done_res;
  assign status_o       = res_q.status;

endmodule

`default_nettype wire

// ===== sv/fpbe_parser.sv =====
`default_nettype none

module fpbe_parser #(
  parameter int unsigned LengthBits = fpbe_pkg::LengthBitsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       take_i,
  input  wire logic [fpbe_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                       end_of_file_i,
  output fpbe_pkg::res_t                  res_o,
  output logic                            res_valid_o
);

  // parse phases
  localparam logic [3:0] PhSig     = 4'd0;
  localparam logic [3:0] PhHdr     = 4'd1;
  localparam logic [3:0] PhSkipBlk = 4'd2;
  localparam logic [3:0] PhPtype   = 4'd3;
  localparam logic [3:0] PhMimeLen = 4'd4;
  localparam logic [3:0] PhMime    = 4'd5;
  localparam logic [3:0] PhDescLen = 4'd6;
  localparam logic [3:0] PhDesc    = 4'd7;
  localparam logic [3:0] PhDims    = 4'd8;
  localparam logic [3:0] PhPicLen  = 4'd9;
  localparam logic [3:0] PhPayload = 4'd10;
  localparam logic [3:0] PhWait    = 4'd11;

  localparam logic [31:0] SigWord = 32'h664C6143;
  localparam logic [6:0]  PictureType = 7'd6;
  localparam logic [fpbe_pkg::SizeW-1:0] MinPicture = 24'd32;
  localparam logic [fpbe_pkg::SizeW-1:0] DimsBytes  = 24'd16;
  localparam logic [fpbe_pkg::SizeW-1:0] LenBytes   = 24'd4;
  localparam logic [fpbe_pkg::SizeW-1:0] TailBytes  = 24'd20;

  logic [3:0]                   phase_q, phase_d;
  logic [1:0]                   idx_q, idx_d;
  logic [31:0]                  acc_q, acc_d;
  logic [fpbe_pkg::SizeW-1:0]   blk_q, blk_d;
  logic [fpbe_pkg::SizeW-1:0]   skip_q, skip_d;
  logic                         fin_q, fin_d;
  logic [fpbe_pkg::ByteW-1:0]   htype_q, htype_d;

  logic [31:0]                  acc_sh;
  logic                         four;
  logic [1:0]                   idx_inc;
  logic [fpbe_pkg::SizeW-1:0]   blk_dec;
  logic [fpbe_pkg::SizeW-1:0]   skip_dec;
  logic [fpbe_pkg::SizeW-1:0]   hdr_size;
  logic [LengthBits-1:0]        len;
  logic [LengthBits-1:0]        blk_ext;
  logic                         go_rest, go_desclen, go_dims, end_blk;
  logic                         done;
  logic [fpbe_pkg::StatusW-1:0] status;
  logic                         pay_valid, pay_last;

  // shared datapath pieces
  assign acc_sh   = {acc_q[23:0], data_byte_i};
  assign four     = (idx_q == 2'd3);
  assign idx_inc  = four ? 2'd0 : idx_q + 2'd1;
  assign blk_dec  = blk_q - 24'd1;
  assign skip_dec = skip_q - 24'd1;
  assign hdr_size = acc_sh[fpbe_pkg::SizeW-1:0];
  assign len      = acc_sh[LengthBits-1:0];
  assign blk_ext  = LengthBits'(blk_dec);

  // next state and result for one byte
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    blk_d      = blk_q;
    skip_d     = skip_q;
    fin_d      = fin_q;
    htype_d    = htype_q;
    go_rest    = 1'b0;
    go_desclen = 1'b0;
    go_dims    = 1'b0;
    end_blk    = 1'b0;
    done       = 1'b0;
    status     = fpbe_pkg::StatusOk;
    pay_valid  = 1'b0;
    pay_last   = 1'b0;

    case (phase_q)
      PhSig: begin
        acc_d = acc_sh;
        idx_d = idx_inc;
        if (four) begin
          if (acc_sh == SigWord) begin
            phase_d = PhHdr;
            idx_d   = 2'd0;
            acc_d   = '0;
          end else begin
            done    = 1'b1;
            status  = fpbe_pkg::StatusBadSig;
            phase_d = PhWait;
          end
        end
      end
      PhHdr: begin
        if (idx_q == 2'd0) begin
          htype_d = data_byte_i;
        end
        acc_d = acc_sh;
        idx_d = idx_inc;
        if (four) begin
          blk_d = hdr_size;
          fin_d = htype_q[7];
          if (htype_q[6:0] == PictureType && hdr_size >= MinPicture) begin
            phase_d = PhPtype;
            skip_d  = LenBytes;
          end else begin
            go_rest = 1'b1;
          end
        end
      end
      PhSkipBlk: begin
        blk_d = blk_dec;
        if (blk_dec == '0) begin
          end_blk = 1'b1;
        end
      end
      PhPtype: begin
        blk_d  = blk_dec;
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PhMimeLen;
          idx_d   = 2'd0;
          acc_d   = '0;
        end
      end
      PhMimeLen, PhDescLen: begin
        blk_d = blk_dec;
        acc_d = acc_sh;
        idx_d = idx_inc;
        if (four) begin
          if (len > blk_ext) begin
            go_rest = 1'b1;
          end else if (len == '0) begin
            if (phase_q == PhMimeLen) begin
              go_desclen = 1'b1;
            end else begin
              go_dims = 1'b1;
            end
          end else begin
            phase_d = (phase_q == PhMimeLen) ? PhMime : PhDesc;
            skip_d  = len[fpbe_pkg::SizeW-1:0];
          end
        end
      end
      PhMime: begin
        blk_d  = blk_dec;
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          go_desclen = 1'b1;
        end
      end
      PhDesc: begin
        blk_d  = blk_dec;
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          go_dims = 1'b1;
        end
      end
      PhDims: begin
        blk_d  = blk_dec;
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PhPicLen;
          idx_d   = 2'd0;
          acc_d   = '0;
        end
      end
      PhPicLen: begin
        blk_d = blk_dec;
        acc_d = acc_sh;
        idx_d = idx_inc;
        if (four) begin
          // payload count is cut at the end of the block
          if (len < blk_ext) begin
            skip_d = len[fpbe_pkg::SizeW-1:0];
          end else begin
            skip_d = blk_dec;
          end
          if (skip_d == '0) begin
            done    = 1'b1;
            status  = fpbe_pkg::StatusOk;
            phase_d = PhWait;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        blk_d     = blk_dec;
        skip_d    = skip_dec;
        pay_valid = 1'b1;
        if (skip_dec == '0) begin
          pay_last = 1'b1;
          done     = 1'b1;
          status   = fpbe_pkg::StatusOk;
          phase_d  = PhWait;
        end
      end
      default: begin
      end
    endcase

    // description length needs four bytes left in the block
    if (go_desclen) begin
      if (blk_d < LenBytes) begin
        go_rest = 1'b1;
      end else begin
        phase_d = PhDescLen;
        idx_d   = 2'd0;
        acc_d   = '0;
      end
    end

    // dimensions plus picture length need twenty bytes
    if (go_dims) begin
      if (blk_d < TailBytes) begin
        go_rest = 1'b1;
      end else begin
        phase_d = PhDims;
        skip_d  = DimsBytes;
      end
    end

    // skip what is left of the block
    if (go_rest) begin
      if (blk_d == '0) begin
        end_blk = 1'b1;
      end else begin
        phase_d = PhSkipBlk;
      end
    end

    // block finished: next header or no picture at all
    if (end_blk) begin
      if (fin_d) begin
        done    = 1'b1;
        status  = fpbe_pkg::StatusNoPicture;
        phase_d = PhWait;
      end else begin
        phase_d = PhHdr;
        idx_d   = 2'd0;
        acc_d   = '0;
      end
    end

    // end of file reports where it stopped and rearms the parser
    if (end_of_file_i) begin
      if (!done && phase_d < PhWait) begin
        done = 1'b1;
        if (phase_d == PhSig) begin
          status = fpbe_pkg::StatusBadSig;
        end else if (phase_d == PhHdr) begin
          status = fpbe_pkg::StatusNoPicture;
        end else begin
          status = fpbe_pkg::StatusTruncated;
        end
      end
      phase_d = PhSig;
      idx_d   = '0;
      acc_d   = '0;
      blk_d   = '0;
      skip_d  = '0;
      fin_d   = 1'b0;
      htype_d = '0;
    end
  end

  // result of this byte
  assign res_valid_o        = pay_valid | done;
  assign res_o.out_byte     = pay_valid ? data_byte_i : '0;
  assign res_o.out_valid    = pay_valid;
  assign res_o.picture_last = pay_last;
  assign res_o.done_res     = done;
  assign res_o.status       = status;

  // parser state, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSig;
      idx_q   <= '0;
      acc_q   <= '0;
      blk_q   <= '0;
      skip_q  <= '0;
      fin_q   <= 1'b0;
      htype_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      blk_q   <= blk_d;
      skip_q  <= skip_d;
      fin_q   <= fin_d;
      htype_q <= htype_d;
    end
  end

endmodule

`default_nettype wire
